>>> sv/lfk_pkg.sv
// shared types, constants and arithmetic helpers for the leg kinematics pipeline
package lfk_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int JOINT_COUNT  = 6;
  localparam int ATAN_LEN     = 24;
  localparam int NUM_STEPS    = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam int STEP_W       = $clog2(ATAN_LEN);
  localparam int JIDX_W       = $clog2(JOINT_COUNT);
  localparam int W            = 34;

  localparam int ANG_W  = 16;
  localparam int POS_W  = 22;
  localparam int QUAT_W = 18;

  typedef logic signed [W-1:0] fix_t;

  localparam longint ONE_Q30       = 64'sd1073741824;
  localparam longint HALF_Q30      = 64'sd536870912;
  localparam longint PI_Q30        = 64'sd3373259426;
  localparam longint HALF_PI_Q30   = 64'sd1686629713;
  localparam longint GAIN_Q30      = 64'sd652032874;
  localparam longint TILT_HALF_Q30 = 64'sd93898724;

  localparam fix_t ONE_FIX     = fix_t'(ONE_Q30);
  localparam fix_t PI_FIX      = fix_t'(PI_Q30);
  localparam fix_t HALF_PI_FIX = fix_t'(HALF_PI_Q30);
  localparam fix_t GAIN_FIX    = fix_t'(GAIN_Q30);

  localparam longint POS_LIM  = 64'sd1048576;
  localparam longint QUAT_LIM = 64'sd65536;

  localparam longint ATAN_Q30 [ATAN_LEN] = '{
    843314857, 497837830, 263043837, 133525159, 67021688, 33543516,
    16775851, 8388438, 4194283, 2097150, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128
  };

  typedef enum logic [1:0] {AXIS_X, AXIS_Y, AXIS_Z} axis_e;
  typedef enum logic [1:0] {TILT_NONE, TILT_NEG, TILT_POS} tilt_e;

  localparam int OFF_X [JOINT_COUNT] = '{0, 0, 26215, -82075, 0, 0};
  localparam int OFF_Y [JOINT_COUNT] = '{67583, 54526, 0, 2253, -99, 0};
  localparam int OFF_Z [JOINT_COUNT] = '{-107689, -31945, -130149, -185954, -314583, -18411};
  localparam tilt_e TILT_SIGN [JOINT_COUNT] =
    '{TILT_NONE, TILT_NEG, TILT_NONE, TILT_POS, TILT_NONE, TILT_NONE};
  localparam axis_e JOINT_AXIS [JOINT_COUNT] =
    '{AXIS_Y, AXIS_X, AXIS_Z, AXIS_Y, AXIS_Y, AXIS_X};

  typedef struct packed {fix_t w; fix_t x; fix_t y; fix_t z;} quat_t;
  typedef struct packed {fix_t x; fix_t y; fix_t z;} vec_t;
  typedef struct packed {fix_t c; fix_t s;} cs_t;

  typedef struct packed {
    logic side;
    quat_t q;
    vec_t p;
    cs_t [JOINT_COUNT-1:0] cs;
  } kin_t;

  typedef struct packed {fix_t x; fix_t y; fix_t z;} cordic_lane_t;

  typedef struct packed {
    logic side;
    logic [JOINT_COUNT-1:0] flip;
    cordic_lane_t [JOINT_COUNT-1:0] lane;
  } cordic_t;

  typedef struct packed {
    fix_t xx; fix_t yy; fix_t zz;
    fix_t xy; fix_t xz; fix_t yz;
    fix_t wx; fix_t wy; fix_t wz;
  } prod_t;

  function automatic longint cordic_cs(longint h_in, bit want_sin);
    longint h, x, y, z, dx, dy;
    bit flip;
    h = h_in;
    flip = 1'b0;
    x = GAIN_Q30;
    y = 0;
    if (h > HALF_PI_Q30) begin
      h = h - PI_Q30;
      flip = 1'b1;
    end else if (h < -HALF_PI_Q30) begin
      h = h + PI_Q30;
      flip = 1'b1;
    end
    z = h;
    for (int i = 0; i < NUM_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - ATAN_Q30[i];
      end else begin
        x = x + dx; y = y - dy; z = z + ATAN_Q30[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    return want_sin ? y : x;
  endfunction

  localparam fix_t TILT_COS_POS = fix_t'(cordic_cs(TILT_HALF_Q30, 1'b0));
  localparam fix_t TILT_SIN_POS = fix_t'(cordic_cs(TILT_HALF_Q30, 1'b1));
  localparam fix_t TILT_COS_NEG = fix_t'(cordic_cs(-TILT_HALF_Q30, 1'b0));
  localparam fix_t TILT_SIN_NEG = fix_t'(cordic_cs(-TILT_HALF_Q30, 1'b1));

  function automatic logic signed [63:0] mul64(fix_t a, fix_t b);
    logic signed [63:0] ea, eb;
    ea = a;
    eb = b;
    return ea * eb;
  endfunction

  function automatic fix_t rnd30(logic signed [63:0] s);
    logic signed [63:0] t;
    t = s + 64'(HALF_Q30);
    return t[63:30];
  endfunction

  function automatic quat_t qmul(quat_t a, quat_t b);
    quat_t r;
    r.w = rnd30(mul64(a.w, b.w) - mul64(a.x, b.x) - mul64(a.y, b.y) - mul64(a.z, b.z));
    r.x = rnd30(mul64(a.w, b.x) + mul64(a.x, b.w) + mul64(a.y, b.z) - mul64(a.z, b.y));
    r.y = rnd30(mul64(a.w, b.y) - mul64(a.x, b.z) + mul64(a.y, b.w) + mul64(a.z, b.x));
    r.z = rnd30(mul64(a.w, b.z) + mul64(a.x, b.y) - mul64(a.y, b.x) + mul64(a.z, b.w));
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(fix_t p);
    fix_t t;
    t = (p + fix_t'(512)) >>> 10;
    if (t > fix_t'(POS_LIM)) return POS_W'(POS_LIM);
    if (t < -fix_t'(POS_LIM)) return POS_W'(-POS_LIM);
    return t[POS_W-1:0];
  endfunction

  function automatic logic signed [QUAT_W-1:0] sat_quat(fix_t q);
    fix_t t;
    t = (q + fix_t'(8192)) >>> 14;
    if (t > fix_t'(QUAT_LIM)) return QUAT_W'(QUAT_LIM);
    if (t < -fix_t'(QUAT_LIM)) return QUAT_W'(-QUAT_LIM);
    return t[QUAT_W-1:0];
  endfunction

endpackage

>>> sv/lfk_if.sv
// joint vector and pose channel interfaces
interface lfk_in_if;
  logic valid;
  logic ready;
  logic side;
  logic signed [15:0] hip_pitch_angle;
  logic signed [15:0] hip_roll_angle;
  logic signed [15:0] hip_yaw_angle;
  logic signed [15:0] knee_angle;
  logic signed [15:0] ankle_pitch_angle;
  logic signed [15:0] ankle_roll_angle;
  modport source (output valid, side, hip_pitch_angle, hip_roll_angle, hip_yaw_angle,
                  knee_angle, ankle_pitch_angle, ankle_roll_angle, input ready);
  modport sink (input valid, side, hip_pitch_angle, hip_roll_angle, hip_yaw_angle,
                knee_angle, ankle_pitch_angle, ankle_roll_angle, output ready);
endinterface

interface lfk_out_if;
  logic valid;
  logic ready;
  logic signed [21:0] pos_x;
  logic signed [21:0] pos_y;
  logic signed [21:0] pos_z;
  logic signed [17:0] quat_w;
  logic signed [17:0] quat_x;
  logic signed [17:0] quat_y;
  logic signed [17:0] quat_z;
  modport source (output valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
                output ready);
endinterface

>>> sv/leg_forward_kinematics.sv
// leg forward kinematics top level: angle fold, cordic chain, joint chain, output rounding
// Fully pipelined: one joint vector is taken every clock while the chain is not
// held. Its pose passes through one input register, one cordic cell per step,
// three stages per joint cell for six joints, and the output register. The
// whole chain advances together; it holds only while the output register is
// full and the sink is not ready.
module leg_forward_kinematics (
  input  logic     clk_i,
  input  logic     rst_ni,
  lfk_in_if.sink   in_i,
  lfk_out_if.source out_o
);

  localparam int NS = lfk_pkg::NUM_STEPS;
  localparam int NJ = lfk_pkg::JOINT_COUNT;

  logic en;
  logic out_v_q;

  logic             cd_v [NS+1];
  lfk_pkg::cordic_t cd   [NS+1];
  lfk_pkg::cordic_t cd0_d;
  lfk_pkg::kin_t    kn   [NJ+1];
  logic             kn_v [NJ+1];

  logic signed [lfk_pkg::POS_W-1:0]  px_d, py_d, pz_d;
  logic signed [lfk_pkg::QUAT_W-1:0] qw_d, qx_d, qy_d, qz_d;
  logic signed [lfk_pkg::POS_W-1:0]  px_q, py_q, pz_q;
  logic signed [lfk_pkg::QUAT_W-1:0] qw_q, qx_q, qy_q, qz_q;

  assign en        = !out_v_q || out_o.ready;
  assign in_i.ready = en;

  always_comb begin
    logic signed [lfk_pkg::ANG_W-1:0] ang [NJ];
    lfk_pkg::fix_t h;
    ang[0] = in_i.hip_pitch_angle;
    ang[1] = in_i.hip_roll_angle;
    ang[2] = in_i.hip_yaw_angle;
    ang[3] = in_i.knee_angle;
    ang[4] = in_i.ankle_pitch_angle;
    ang[5] = in_i.ankle_roll_angle;
    cd0_d.side = in_i.side;
    for (int l = 0; l < NJ; l++) begin
      h = {{(lfk_pkg::W-lfk_pkg::ANG_W-16){ang[l][lfk_pkg::ANG_W-1]}}, ang[l], 16'b0};
      cd0_d.flip[l]   = 1'b0;
      cd0_d.lane[l].x = lfk_pkg::GAIN_FIX;
      cd0_d.lane[l].y = '0;
      if (h > lfk_pkg::HALF_PI_FIX) begin
        h = h - lfk_pkg::PI_FIX;
        cd0_d.flip[l] = 1'b1;
      end else if (h < -lfk_pkg::HALF_PI_FIX) begin
        h = h + lfk_pkg::PI_FIX;
        cd0_d.flip[l] = 1'b1;
      end
      cd0_d.lane[l].z = h;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cd_v[0] <= 1'b0;
    end else if (en) begin
      cd_v[0] <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cd[0] <= cd0_d;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_cordic
    lfk_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .step_i  (lfk_pkg::STEP_W'(k)),
      .valid_i (cd_v[k]),
      .data_i  (cd[k]),
      .valid_o (cd_v[k+1]),
      .data_o  (cd[k+1])
    );
  end

  always_comb begin
    kn[0].side = cd[NS].side;
    kn[0].q    = '{w: lfk_pkg::ONE_FIX, x: '0, y: '0, z: '0};
    kn[0].p    = '0;
    for (int l = 0; l < NJ; l++) begin
      kn[0].cs[l].c = cd[NS].flip[l] ? -cd[NS].lane[l].x : cd[NS].lane[l].x;
      kn[0].cs[l].s = cd[NS].flip[l] ? -cd[NS].lane[l].y : cd[NS].lane[l].y;
    end
  end
  assign kn_v[0] = cd_v[NS];

  for (genvar j = 0; j < NJ; j++) begin : g_joint
    lfk_joint_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .joint_i (lfk_pkg::JIDX_W'(j)),
      .valid_i (kn_v[j]),
      .data_i  (kn[j]),
      .valid_o (kn_v[j+1]),
      .data_o  (kn[j+1])
    );
  end

  always_comb begin
    px_d = lfk_pkg::sat_pos(kn[NJ].p.x);
    py_d = lfk_pkg::sat_pos(kn[NJ].p.y);
    pz_d = lfk_pkg::sat_pos(kn[NJ].p.z);
    qw_d = lfk_pkg::sat_quat(kn[NJ].q.w);
    qx_d = lfk_pkg::sat_quat(kn[NJ].q.x);
    qy_d = lfk_pkg::sat_quat(kn[NJ].q.y);
    qz_d = lfk_pkg::sat_quat(kn[NJ].q.z);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= kn_v[NJ];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q <= px_d;
      py_q <= py_d;
      pz_q <= pz_d;
      qw_q <= qw_d;
      qx_q <= qx_d;
      qy_q <= qy_d;
      qz_q <= qz_d;
    end
  end

  assign out_o.valid  = out_v_q;
  assign out_o.pos_x  = px_q;
  assign out_o.pos_y  = py_q;
  assign out_o.pos_z  = pz_q;
  assign out_o.quat_w = qw_q;
  assign out_o.quat_x = qx_q;
  assign out_o.quat_y = qy_q;
  assign out_o.quat_z = qz_q;

endmodule

>>> sv/lfk_cordic_cell.sv
// one cordic rotation step applied to all joint lanes
module lfk_cordic_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [lfk_pkg::STEP_W-1:0]    step_i,
  input  logic                          valid_i,
  input  lfk_pkg::cordic_t              data_i,
  output logic                          valid_o,
  output lfk_pkg::cordic_t              data_o
);

  lfk_pkg::cordic_t data_d, data_q;
  logic             valid_q;
  lfk_pkg::fix_t    atan_c;

  assign atan_c = lfk_pkg::fix_t'(lfk_pkg::ATAN_Q30[step_i]);

  always_comb begin
    lfk_pkg::fix_t dx, dy;
    data_d = data_i;
    for (int l = 0; l < lfk_pkg::JOINT_COUNT; l++) begin
      dx = data_i.lane[l].y >>> step_i;
      dy = data_i.lane[l].x >>> step_i;
      if (!data_i.lane[l].z[lfk_pkg::W-1]) begin
        data_d.lane[l].x = data_i.lane[l].x - dx;
        data_d.lane[l].y = data_i.lane[l].y + dy;
        data_d.lane[l].z = data_i.lane[l].z - atan_c;
      end else begin
        data_d.lane[l].x = data_i.lane[l].x + dx;
        data_d.lane[l].y = data_i.lane[l].y - dy;
        data_d.lane[l].z = data_i.lane[l].z + atan_c;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> sv/lfk_joint_cell.sv
// one frame of the chain: offset rotate-add, fixed pitch and joint rotation
module lfk_joint_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic [lfk_pkg::JIDX_W-1:0]   joint_i,
  input  logic                         valid_i,
  input  lfk_pkg::kin_t                data_i,
  output logic                         valid_o,
  output lfk_pkg::kin_t                data_o
);

  // stage a: matrix products and fixed pitch
  logic            a_v_q;
  lfk_pkg::kin_t   a_kin_q;
  lfk_pkg::prod_t  a_p_d, a_p_q;
  lfk_pkg::quat_t  a_qt_d, a_qt_q;

  // stage b: offset products and joint rotation
  logic            b_v_q;
  lfk_pkg::kin_t   b_kin_d, b_kin_q;
  lfk_pkg::fix_t   b_t_d [3][3];
  lfk_pkg::fix_t   b_t_q [3][3];

  // stage c: position accumulate
  logic            c_v_q;
  lfk_pkg::kin_t   c_kin_d, c_kin_q;

  always_comb begin
    lfk_pkg::quat_t q, tq;
    q = data_i.q;
    a_p_d.xx = lfk_pkg::rnd30(lfk_pkg::mul64(q.x, q.x));
    a_p_d.yy = lfk_pkg::rnd30(lfk_pkg::mul64(q.y, q.y));
    a_p_d.zz = lfk_pkg::rnd30(lfk_pkg::mul64(q.z, q.z));
    a_p_d.xy = lfk_pkg::rnd30(lfk_pkg::mul64(q.x, q.y));
    a_p_d.xz = lfk_pkg::rnd30(lfk_pkg::mul64(q.x, q.z));
    a_p_d.yz = lfk_pkg::rnd30(lfk_pkg::mul64(q.y, q.z));
    a_p_d.wx = lfk_pkg::rnd30(lfk_pkg::mul64(q.w, q.x));
    a_p_d.wy = lfk_pkg::rnd30(lfk_pkg::mul64(q.w, q.y));
    a_p_d.wz = lfk_pkg::rnd30(lfk_pkg::mul64(q.w, q.z));
    tq = '{w: lfk_pkg::ONE_FIX, x: '0, y: '0, z: '0};
    unique case (lfk_pkg::TILT_SIGN[joint_i])
      lfk_pkg::TILT_NEG: begin
        tq = '{w: lfk_pkg::TILT_COS_NEG, x: '0, y: lfk_pkg::TILT_SIN_NEG, z: '0};
        a_qt_d = lfk_pkg::qmul(q, tq);
      end
      lfk_pkg::TILT_POS: begin
        tq = '{w: lfk_pkg::TILT_COS_POS, x: '0, y: lfk_pkg::TILT_SIN_POS, z: '0};
        a_qt_d = lfk_pkg::qmul(q, tq);
      end
      default: a_qt_d = q;
    endcase
  end

  always_comb begin
    lfk_pkg::fix_t  m [3][3];
    lfk_pkg::fix_t  v [3];
    lfk_pkg::fix_t  oy;
    lfk_pkg::quat_t jq;
    lfk_pkg::cs_t   cs;
    m[0][0] = lfk_pkg::ONE_FIX - ((a_p_q.yy + a_p_q.zz) <<< 1);
    m[0][1] = (a_p_q.xy - a_p_q.wz) <<< 1;
    m[0][2] = (a_p_q.xz + a_p_q.wy) <<< 1;
    m[1][0] = (a_p_q.xy + a_p_q.wz) <<< 1;
    m[1][1] = lfk_pkg::ONE_FIX - ((a_p_q.xx + a_p_q.zz) <<< 1);
    m[1][2] = (a_p_q.yz - a_p_q.wx) <<< 1;
    m[2][0] = (a_p_q.xz - a_p_q.wy) <<< 1;
    m[2][1] = (a_p_q.yz + a_p_q.wx) <<< 1;
    m[2][2] = lfk_pkg::ONE_FIX - ((a_p_q.xx + a_p_q.yy) <<< 1);
    oy   = lfk_pkg::fix_t'(lfk_pkg::OFF_Y[joint_i]) <<< 10;
    v[0] = lfk_pkg::fix_t'(lfk_pkg::OFF_X[joint_i]) <<< 10;
    v[1] = a_kin_q.side ? -oy : oy;
    v[2] = lfk_pkg::fix_t'(lfk_pkg::OFF_Z[joint_i]) <<< 10;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        b_t_d[r][c] = lfk_pkg::rnd30(lfk_pkg::mul64(m[r][c], v[c]));
      end
    end
    cs = a_kin_q.cs[joint_i];
    jq = '{w: cs.c, x: '0, y: '0, z: '0};
    unique case (lfk_pkg::JOINT_AXIS[joint_i])
      lfk_pkg::AXIS_X: jq.x = cs.s;
      lfk_pkg::AXIS_Y: jq.y = cs.s;
      default:         jq.z = cs.s;
    endcase
    b_kin_d   = a_kin_q;
    b_kin_d.q = lfk_pkg::qmul(a_qt_q, jq);
  end

  always_comb begin
    c_kin_d     = b_kin_q;
    c_kin_d.p.x = b_kin_q.p.x + b_t_q[0][0] + b_t_q[0][1] + b_t_q[0][2];
    c_kin_d.p.y = b_kin_q.p.y + b_t_q[1][0] + b_t_q[1][1] + b_t_q[1][2];
    c_kin_d.p.z = b_kin_q.p.z + b_t_q[2][0] + b_t_q[2][1] + b_t_q[2][2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else if (en_i) begin
      a_v_q <= valid_i;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_kin_q <= data_i;
      a_p_q   <= a_p_d;
      a_qt_q  <= a_qt_d;
      b_kin_q <= b_kin_d;
      b_t_q   <= b_t_d;
      c_kin_q <= c_kin_d;
    end
  end

  assign valid_o = c_v_q;
  assign data_o  = c_kin_q;

endmodule

>>> sim/leg_forward_kinematics_test.sv
// self-checking testbench for the leg forward kinematics pipeline
module leg_forward_kinematics_test;

  localparam int LATENCY   = 36;
  localparam int IDLE_LIM  = 4000;
  localparam int ANG_LIM   = 25736;

  typedef struct {
    logic side;
    logic signed [15:0] ang [6];
  } joints_t;

  typedef struct {
    logic signed [21:0] px, py, pz;
    logic signed [17:0] qw, qx, qy, qz;
  } pose_t;

  typedef struct {longint w, x, y, z;} q64_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  lfk_in_if  jin();
  lfk_out_if pout();

  leg_forward_kinematics u_top (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(jin), .out_o(pout));

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  pose_t pose_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_sink = 1'b0;
  bit sink_rand = 1'b1;

  localparam int OX [6] = '{0, 0, 26215, -82075, 0, 0};
  localparam int OY [6] = '{67583, 54526, 0, 2253, -99, 0};
  localparam int OZ [6] = '{-107689, -31945, -130149, -185954, -314583, -18411};
  localparam int TS [6] = '{0, -1, 0, 1, 0, 0};
  localparam int AX [6] = '{1, 0, 2, 1, 1, 0};
  localparam longint ATN [24] = '{
    843314857, 497837830, 263043837, 133525159, 67021688, 33543516,
    16775851, 8388438, 4194283, 2097150, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};

  function automatic longint rq(longint s);
    return (s + 64'sd536870912) >>> 30;
  endfunction

  function automatic q64_t half_rot(longint h, int axis);
    q64_t r;
    longint x, y, z, dx, dy;
    bit flip;
    x = 64'sd652032874;
    y = 0;
    flip = 0;
    if (h > 64'sd1686629713) begin
      h -= 64'sd3373259426; flip = 1;
    end else if (h < -64'sd1686629713) begin
      h += 64'sd3373259426; flip = 1;
    end
    z = h;
    for (int i = 0; i < lfk_pkg::CORDIC_STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATN[i];
      end else begin
        x += dx; y -= dy; z += ATN[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    r = '{x, 0, 0, 0};
    if (axis == 0) r.x = y;
    else if (axis == 1) r.y = y;
    else r.z = y;
    return r;
  endfunction

  function automatic q64_t qprod(q64_t a, q64_t b);
    q64_t r;
    r.w = rq(a.w * b.w - a.x * b.x - a.y * b.y - a.z * b.z);
    r.x = rq(a.w * b.x + a.x * b.w + a.y * b.z - a.z * b.y);
    r.y = rq(a.w * b.y - a.x * b.z + a.y * b.w + a.z * b.x);
    r.z = rq(a.w * b.z + a.x * b.y - a.y * b.x + a.z * b.w);
    return r;
  endfunction

  function automatic longint clamp(longint v, longint lim);
    return v > lim ? lim : (v < -lim ? -lim : v);
  endfunction

  function automatic pose_t leg_pose(joints_t j);
    pose_t r;
    q64_t q;
    longint p [3];
    longint v [3];
    longint m [3][3];
    longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
    q = '{64'sd1073741824, 0, 0, 0};
    p = '{0, 0, 0};
    for (int k = 0; k < 6; k++) begin
      v[0] = longint'(OX[k]) * 1024;
      v[1] = longint'(j.side ? -OY[k] : OY[k]) * 1024;
      v[2] = longint'(OZ[k]) * 1024;
      xx = rq(q.x * q.x); yy = rq(q.y * q.y); zz = rq(q.z * q.z);
      xy = rq(q.x * q.y); xz = rq(q.x * q.z); yz = rq(q.y * q.z);
      wx = rq(q.w * q.x); wy = rq(q.w * q.y); wz = rq(q.w * q.z);
      m[0][0] = 64'sd1073741824 - 2 * (yy + zz);
      m[0][1] = 2 * (xy - wz); m[0][2] = 2 * (xz + wy);
      m[1][0] = 2 * (xy + wz); m[1][1] = 64'sd1073741824 - 2 * (xx + zz);
      m[1][2] = 2 * (yz - wx);
      m[2][0] = 2 * (xz - wy); m[2][1] = 2 * (yz + wx);
      m[2][2] = 64'sd1073741824 - 2 * (xx + yy);
      for (int i = 0; i < 3; i++)
        p[i] += rq(m[i][0] * v[0]) + rq(m[i][1] * v[1]) + rq(m[i][2] * v[2]);
      if (TS[k] != 0)
        q = qprod(q, half_rot(TS[k] > 0 ? 64'sd93898724 : -64'sd93898724, 1));
      q = qprod(q, half_rot(longint'(j.ang[k]) * 65536, AX[k]));
    end
    r.px = 22'(clamp((p[0] + 512) >>> 10, 1048576));
    r.py = 22'(clamp((p[1] + 512) >>> 10, 1048576));
    r.pz = 22'(clamp((p[2] + 512) >>> 10, 1048576));
    r.qw = 18'(clamp((q.w + 8192) >>> 14, 65536));
    r.qx = 18'(clamp((q.x + 8192) >>> 14, 65536));
    r.qy = 18'(clamp((q.y + 8192) >>> 14, 65536));
    r.qz = 18'(clamp((q.z + 8192) >>> 14, 65536));
    return r;
  endfunction

  task automatic send_joints(joints_t j, bit gaps = 1'b1);
    int gap;
    gap = gaps ? $urandom_range(0, 8) : 0;
    if (gap > 0 && $urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      jin.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    jin.valid <= 1'b1;
    jin.side <= j.side;
    jin.hip_pitch_angle <= j.ang[0];
    jin.hip_roll_angle <= j.ang[1];
    jin.hip_yaw_angle <= j.ang[2];
    jin.knee_angle <= j.ang[3];
    jin.ankle_pitch_angle <= j.ang[4];
    jin.ankle_roll_angle <= j.ang[5];
    @(posedge clk_i);
    while (!jin.ready) @(posedge clk_i);
    pose_q.push_back(leg_pose(j));
    @(negedge clk_i);
  endtask

  function automatic joints_t rand_joints(bit any_bits);
    joints_t j;
    j.side = 1'($urandom_range(0, 1));
    for (int k = 0; k < 6; k++)
      j.ang[k] = any_bits ? 16'($urandom) : 16'($signed($urandom_range(0, 2 * ANG_LIM)) - ANG_LIM);
    return j;
  endfunction

  task automatic wait_drain();
    jin.valid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic test_directed();
    joints_t j;
    int pats [6] = '{0, ANG_LIM, -ANG_LIM, 32767, -32768, 12868};
    for (int s = 0; s < 2; s++)
      for (int p = 0; p < 6; p++) begin
        j.side = 1'(s);
        for (int k = 0; k < 6; k++) j.ang[k] = 16'(pats[p]);
        send_joints(j);
      end
    for (int k = 0; k < 6; k++) begin
      j.side = k[0];
      for (int i = 0; i < 6; i++) j.ang[i] = (i == k) ? 16'(ANG_LIM) : 16'(-ANG_LIM);
      send_joints(j);
    end
    wait_drain();
  endtask

  task automatic test_backpressure();
    hold_sink = 1'b1;
    for (int n = 0; n < 80; n++) send_joints(rand_joints(1'b0), 1'b0);
    wait_drain();
  endtask

  task automatic test_random();
    for (int n = 0; n < 1100; n++) begin
      send_joints(rand_joints(n % 4 == 0), n >= 500 && n < 600 ? 1'b0 : 1'b1);
      if (n == 300) wait_drain();
      if (n == 500) sink_rand = 1'b0;
      if (n == 600) sink_rand = 1'b1;
    end
  endtask

  // sink ready with random stalls and one long hold-off
  initial begin
    int stall;
    pout.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_sink) begin
        pout.ready <= 1'b0;
        repeat (200) @(negedge clk_i);
        hold_sink = 1'b0;
      end
      stall = sink_rand ? $urandom_range(0, 8) : 0;
      if (stall > 0 && $urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        pout.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
        @(negedge clk_i);
      end
      pout.ready <= 1'b1;
      @(posedge clk_i);
      while (!pout.valid) @(posedge clk_i);
    end
  end

  // compare each pose transaction with the oldest prediction
  always @(posedge clk_i) begin
    pose_t e;
    if (rst_ni && pout.valid && pout.ready) begin
      if (pose_q.size() == 0) begin
        $display("%0t unexpected pose transaction x=%0d", $time, pout.pos_x);
        errors++;
      end else begin
        e = pose_q.pop_front();
        if ({e.px, e.py, e.pz, e.qw, e.qx, e.qy, e.qz} !==
            {pout.pos_x, pout.pos_y, pout.pos_z, pout.quat_w, pout.quat_x,
             pout.quat_y, pout.quat_z}) begin
          $display("%0t mismatch expected pos %0d %0d %0d quat %0d %0d %0d %0d", $time,
                   e.px, e.py, e.pz, e.qw, e.qx, e.qy, e.qz);
          $display("%0t          actual   pos %0d %0d %0d quat %0d %0d %0d %0d", $time,
                   pout.pos_x, pout.pos_y, pout.pos_z, pout.quat_w, pout.quat_x,
                   pout.quat_y, pout.quat_z);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((jin.valid && jin.ready) || (pout.valid && pout.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIM) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    jin.valid = 1'b0;
    jin.side = 1'b0;
    jin.hip_pitch_angle = '0;
    jin.hip_roll_angle = '0;
    jin.hip_yaw_angle = '0;
    jin.knee_angle = '0;
    jin.ankle_pitch_angle = '0;
    jin.ankle_roll_angle = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_backpressure();
    test_random();
    wait_drain();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (errors == 0 && pose_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
